// ===== rtl/core/qaar_pkg.sv =====
`default_nettype none
package qaar_pkg;

	// CORDIC iterations on the half angle
	localparam int CORDIC_STEPS = 24;

	// root steps for a 64-bit radicand, quotient bits of a unit division
	localparam int ISQ_STEPS = 32;
	localparam int DIV_BITS  = 31;

	// pipeline map
	localparam int K_MUL = 0;
	localparam int K_SUM = 1;
	localparam int K_A   = 2;
	localparam int K_B   = K_A + ISQ_STEPS;
	localparam int K_C   = K_B + 1;
	localparam int K_D   = K_C + 1;
	localparam int K_E   = K_D + ISQ_STEPS;
	localparam int K_F1  = K_E + DIV_BITS;
	localparam int K_F2  = K_F1 + 1;
	localparam int K_G1  = K_F2 + 1;
	localparam int K_G2  = K_G1 + 1;
	localparam int K_H1  = K_G2 + 1;
	localparam int K_H2  = K_H1 + 1;
	localparam int K_H3  = K_H2 + 1;
	localparam int DEPTH = K_H3 + 1;

	// integer square root state
	typedef struct packed {
		logic [64:0] n;
		logic [64:0] r;
	} sq_t;

	// restoring division state
	typedef struct packed {
		logic [62:0] rem;
		logic [30:0] q;
	} dv_t;

	// everything an item carries down the pipeline
	typedef struct packed {
		logic [2:0][31:0] vec;
		logic [31:0]      ang;
		logic [2:0][31:0] axis;
		logic [2:0][63:0] asq;
		logic [63:0]      aprod;
		logic [2:0]       asgn;
		logic [2:0][31:0] amag;
		sq_t              lsq;
		logic [33:0]      cx;
		logic [33:0]      cy;
		logic [33:0]      cz;
		logic             degen;
		logic [31:0]      len;
		logic [1:0][63:0] csq;
		logic [1:0]       csgn;
		logic [1:0][31:0] cmag;
		sq_t              msq;
		dv_t [2:0]        adv;
		dv_t [1:0]        cdv;
		logic [2:0][63:0] qprod;
		logic [31:0]      w;
		logic [2:0][31:0] q;
		logic [8:0][63:0] mprod;
		logic [8:0][33:0] rm;
		logic [8:0][65:0] vprod;
		logic [2:0][67:0] acc;
		logic [2:0][31:0] rot;
	} item_t;

	// arctangent of 2^-i in binary angle units
	function automatic logic [31:0] atan_bin(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			5'd31: a = 32'd0;
		endcase
		return a;
	endfunction

	// one root digit, trial bit 2^(62-2j)
	function automatic sq_t isqrt_step(input sq_t s, input int j);
		logic [64:0] bitv;
		logic [64:0] t;
		sq_t o;
		bitv = 65'd1 << (62 - 2 * j);
		t = s.r + bitv;
		o = s;
		if (s.n >= t) begin
			o.n = s.n - t;
			o.r = (s.r >> 1) + bitv;
		end else begin
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	// one quotient bit at position k
	function automatic dv_t div_step(input dv_t d, input logic [31:0] den, input int k);
		logic [62:0] t;
		dv_t o;
		t = {31'd0, den} << k;
		o = d;
		if (d.rem >= t) begin
			o.rem = d.rem - t;
			o.q = d.q | (31'd1 << k);
		end
		return o;
	endfunction

	// two's complement magnitude
	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	// Q60 to Q30, round half up
	function automatic logic [33:0] rnd66(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = v + 66'sd536870912;
		return t[63:30];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/quaternion_axis_angle_rotate_unit.sv =====
// Throughput: one word per cycle while the output is not stalled; every stage
// holds one item. The depth is set by the 32-step axis and magnitude root chains
// and the 31-step cosine and sine divide; the CORDIC steps run alongside the axis root.
// A stalled output word freezes the whole pipeline until it is taken.
// Reset clears all valid bits and sets axis_epsilon to 1; payload is not reset.
`default_nettype none
module quaternion_axis_angle_rotate_unit
	import qaar_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// vec_x, vec_y, vec_z, angle, axis_x, axis_y, axis_z
	input  wire logic [223:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// rot_x, rot_y, rot_z
	output logic [95:0]       m_axis_tdata,
	// axis_degenerate
	output logic              m_axis_tuser
);

	logic [15:0]      eps_q;
	logic [DEPTH-1:0] v_s;
	item_t            pipe_s [DEPTH];
	item_t            in_item;
	logic             en;

	// work for stage k on the item from the stage before
	function automatic item_t stage_step(input int k, input item_t p, input logic [15:0] eps);
		item_t o;
		logic signed [63:0] sa;
		logic signed [63:0] sb;
		logic [63:0] t64;
		logic [31:0] b32;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] at;
		logic [2:0][31:0] uu;
		logic [31:0] cv;
		logic [31:0] sv;
		logic signed [65:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
		logic signed [65:0] one;
		logic signed [67:0] t68;
		logic signed [37:0] t38;
		int j;
		o = p;
		j = 0;
		if (k == K_MUL) begin
			// axis squares and angle scaling
			for (int i = 0; i < 3; i++) begin
				o.asgn[i] = p.axis[i][31];
				o.amag[i] = mag32(p.axis[i]);
				o.asq[i] = {32'd0, o.amag[i]} * {32'd0, o.amag[i]};
			end
			sa = {{32{p.ang[31]}}, p.ang};
			o.aprod = sa * 64'sd1367130551;
		end else if (k == K_SUM) begin
			// radicand, half angle folded to the right half plane
			o.lsq.n = {1'b0, p.asq[0] + p.asq[1] + p.asq[2]};
			o.lsq.r = '0;
			t64 = p.aprod + 64'd536870912;
			b32 = t64[61:30];
			if (b32[31] ^ b32[30])
				b32[31] = ~b32[31];
			o.cz = {{2{b32[31]}}, b32};
			o.cx = 34'h040000000;
			o.cy = '0;
		end else if (k < K_B) begin
			// axis root and CORDIC side by side
			j = k - K_A;
			o.lsq = isqrt_step(p.lsq, j);
			if (j < CORDIC_STEPS) begin
				dx = $signed(p.cy) >>> j;
				dy = $signed(p.cx) >>> j;
				at = $signed({2'b00, atan_bin(5'(j))});
				if (!p.cz[33]) begin
					o.cx = 34'($signed(p.cx) - dx);
					o.cy = 34'($signed(p.cy) + dy);
					o.cz = 34'($signed(p.cz) - at);
				end else begin
					o.cx = 34'($signed(p.cx) + dx);
					o.cy = 34'($signed(p.cy) - dy);
					o.cz = 34'($signed(p.cz) + at);
				end
			end
		end else if (k == K_B) begin
			// short axis test, CORDIC squares, divider set-up
			o.len = p.lsq.r[31:0];
			o.degen = (p.lsq.r <= {49'd0, eps});
			o.csgn[0] = p.cx[33];
			o.csgn[1] = p.cy[33];
			o.cmag[0] = p.cx[33] ? 32'(-$signed(p.cx)) : p.cx[31:0];
			o.cmag[1] = p.cy[33] ? 32'(-$signed(p.cy)) : p.cy[31:0];
			for (int i = 0; i < 2; i++)
				o.csq[i] = {32'd0, o.cmag[i]} * {32'd0, o.cmag[i]};
			for (int i = 0; i < 3; i++) begin
				o.adv[i].rem = {31'd0, p.amag[i]} << 30;
				o.adv[i].q = '0;
			end
		end else if (k == K_C) begin
			o.msq.n = {1'b0, p.csq[0]} + {1'b0, p.csq[1]};
			o.msq.r = '0;
		end else if (k < K_E) begin
			// CORDIC magnitude root, axis divide alongside
			j = k - K_D;
			o.msq = isqrt_step(p.msq, j);
			if (j < DIV_BITS) begin
				for (int i = 0; i < 3; i++)
					o.adv[i] = div_step(p.adv[i], p.len, DIV_BITS - 1 - j);
			end else begin
				for (int i = 0; i < 2; i++) begin
					o.cdv[i].rem = {31'd0, p.cmag[i]} << 30;
					o.cdv[i].q = '0;
				end
			end
		end else if (k < K_F1) begin
			// cosine and sine over their magnitude
			j = k - K_E;
			for (int i = 0; i < 2; i++)
				o.cdv[i] = div_step(p.cdv[i], p.msq.r[31:0], DIV_BITS - 1 - j);
		end else if (k == K_F1) begin
			// signed unit axis times sine
			for (int i = 0; i < 3; i++)
				uu[i] = p.asgn[i] ? 32'(-{1'b0, p.adv[i].q}) : {1'b0, p.adv[i].q};
			if (p.msq.r == '0) begin
				cv = 32'h40000000;
				sv = '0;
			end else begin
				cv = p.csgn[0] ? 32'(-{1'b0, p.cdv[0].q}) : {1'b0, p.cdv[0].q};
				sv = p.csgn[1] ? 32'(-{1'b0, p.cdv[1].q}) : {1'b0, p.cdv[1].q};
			end
			o.w = cv;
			sb = {{32{sv[31]}}, sv};
			for (int i = 0; i < 3; i++) begin
				sa = {{32{uu[i][31]}}, uu[i]};
				o.qprod[i] = sa * sb;
			end
		end else if (k == K_F2) begin
			for (int i = 0; i < 3; i++) begin
				t64 = p.qprod[i] + 64'd536870912;
				o.q[i] = t64[61:30];
			end
		end else if (k == K_G1) begin
			// quaternion products: xx yy zz xy xz yz wx wy wz
			for (int i = 0; i < 3; i++) begin
				sa = {{32{p.q[i][31]}}, p.q[i]};
				o.mprod[i] = sa * sa;
			end
			sa = {{32{p.q[0][31]}}, p.q[0]};
			sb = {{32{p.q[1][31]}}, p.q[1]};
			o.mprod[3] = sa * sb;
			sb = {{32{p.q[2][31]}}, p.q[2]};
			o.mprod[4] = sa * sb;
			sa = {{32{p.q[1][31]}}, p.q[1]};
			o.mprod[5] = sa * sb;
			sb = {{32{p.w[31]}}, p.w};
			for (int i = 0; i < 3; i++) begin
				sa = {{32{p.q[i][31]}}, p.q[i]};
				o.mprod[6 + i] = sb * sa;
			end
		end else if (k == K_G2) begin
			// rotation matrix, Q30
			xx = {{2{p.mprod[0][63]}}, p.mprod[0]};
			yy = {{2{p.mprod[1][63]}}, p.mprod[1]};
			zz = {{2{p.mprod[2][63]}}, p.mprod[2]};
			xy = {{2{p.mprod[3][63]}}, p.mprod[3]};
			xz = {{2{p.mprod[4][63]}}, p.mprod[4]};
			yz = {{2{p.mprod[5][63]}}, p.mprod[5]};
			wx = {{2{p.mprod[6][63]}}, p.mprod[6]};
			wy = {{2{p.mprod[7][63]}}, p.mprod[7]};
			wz = {{2{p.mprod[8][63]}}, p.mprod[8]};
			one = 66'sh1000000000000000;
			o.rm[0] = rnd66(one - ((yy + zz) <<< 1));
			o.rm[1] = rnd66((xy - wz) <<< 1);
			o.rm[2] = rnd66((xz + wy) <<< 1);
			o.rm[3] = rnd66((xy + wz) <<< 1);
			o.rm[4] = rnd66(one - ((xx + zz) <<< 1));
			o.rm[5] = rnd66((yz - wx) <<< 1);
			o.rm[6] = rnd66((xz - wy) <<< 1);
			o.rm[7] = rnd66((yz + wx) <<< 1);
			o.rm[8] = rnd66(one - ((xx + yy) <<< 1));
		end else if (k == K_H1) begin
			// matrix times vector
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					o.vprod[3 * i + c] = $signed({{32{p.rm[3 * i + c][33]}}, p.rm[3 * i + c]})
						* $signed({{34{p.vec[c][31]}}, p.vec[c]});
				end
			end
		end else if (k == K_H2) begin
			for (int i = 0; i < 3; i++) begin
				o.acc[i] = {{2{p.vprod[3 * i][65]}}, p.vprod[3 * i]}
					+ {{2{p.vprod[3 * i + 1][65]}}, p.vprod[3 * i + 1]}
					+ {{2{p.vprod[3 * i + 2][65]}}, p.vprod[3 * i + 2]};
			end
		end else begin
			// round, saturate, or pass the vector on a short axis
			for (int i = 0; i < 3; i++) begin
				t68 = $signed(p.acc[i]) + 68'sd536870912;
				t38 = t68[67:30];
				if (p.degen)
					o.rot[i] = p.vec[i];
				else if (t38 > 38'sh007FFFFFFF)
					o.rot[i] = 32'h7FFFFFFF;
				else if (t38 < -38'sh0080000000)
					o.rot[i] = 32'h80000000;
				else
					o.rot[i] = t38[31:0];
			end
		end
		return o;
	endfunction

	// epsilon register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd1;
		end else if (cfg_valid) begin
			eps_q <= cfg_data;
		end
	end

	// input word unpack
	always_comb begin
		in_item = '0;
		in_item.vec = s_axis_tdata[95:0];
		in_item.ang = s_axis_tdata[127:96];
		in_item.axis = s_axis_tdata[223:128];
	end

	// whole pipeline advances unless the output word is held
	assign en = !v_s[DEPTH-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DEPTH-2:0], s_axis_tvalid};
		end
	end

	// stage registers
	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		item_t src;
		item_t nxt;
		if (k == 0) begin : g_first
			assign src = in_item;
		end else begin : g_next
			assign src = pipe_s[k-1];
		end
		always_comb nxt = stage_step(k, src, eps_q);
		always_ff @(posedge clk) begin
			if (en)
				pipe_s[k] <= nxt;
		end
	end

	assign m_axis_tvalid = v_s[DEPTH-1];
	assign m_axis_tdata  = pipe_s[DEPTH-1].rot;
	assign m_axis_tuser  = pipe_s[DEPTH-1].degen;

	// a held output word keeps the valid bit of every stage still
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[DEPTH-1] && !m_axis_tready |=> $stable(v_s))
		else $error("pipeline moved while output stalled");

	// an accepted word enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s[0])
		else $error("accepted word lost at entry");

	// unit axis components never exceed one
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[K_F1-1] && !pipe_s[K_F1-1].degen |->
		pipe_s[K_F1-1].adv[0].q <= 31'h40000000 &&
		pipe_s[K_F1-1].adv[1].q <= 31'h40000000 &&
		pipe_s[K_F1-1].adv[2].q <= 31'h40000000)
		else $error("unit axis component out of range");

endmodule
`default_nettype wire

// ===== verif/tb_quaternion_axis_angle_rotate_unit.sv =====
`timescale 1ns / 1ps
module tb_quaternion_axis_angle_rotate_unit;
	import qaar_pkg::*;

	typedef struct packed {
		logic [2:0][31:0] rot;
		logic             degen;
	} rotation_t;

	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint HALF_Q30    = 64'sd536870912;
	localparam longint RAD_TO_BIN  = 64'sd1367130551;
	localparam int     SETTLE      = 110;

	// arctangent of 2^-i, binary angle units
	localparam longint ARCTAN [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [95:0]  m_axis_tdata;
	logic         m_axis_tuser;

	rotation_t    expected_rotations [$];
	logic [15:0]  epsilon_shadow = 16'd1;
	int           mismatches = 0;
	int           burst_left = 0;

	quaternion_axis_angle_rotate_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// fixed-point helpers
	function automatic longint unsigned abs64(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint round30(input longint v);
		return (v + HALF_Q30) >>> 30;
	endfunction

	function automatic longint unsigned root64(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint scale_q30(input longint num, input longint unsigned den);
		longint unsigned qq;
		qq = (abs64(num) << 30) / den;
		return num < 0 ? -longint'(qq) : longint'(qq);
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// expected output word for one input word
	function automatic rotation_t rotate_vector(input logic [223:0] d, input logic [15:0] eps);
		longint v [3], a [3], u [3], q [3], r [3][3];
		longint x, y, z, c, s, w, acc, dx, dy, one;
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
		longint unsigned sq, len, m;
		logic [31:0] b;
		rotation_t res;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			v[i] = longint'($signed(d[32*i +: 32]));
			a[i] = longint'($signed(d[128 + 32*i +: 32]));
			sq += abs64(a[i]) * abs64(a[i]);
		end
		len = root64(sq);
		if (len <= longint'(eps)) begin
			for (int i = 0; i < 3; i++)
				res.rot[i] = v[i][31:0];
			res.degen = 1'b1;
			return res;
		end
		for (int i = 0; i < 3; i++)
			u[i] = scale_q30(a[i], len);

		// half angle in binary units, folded into +-pi/2
		b = 32'(round30(longint'($signed(d[96 +: 32])) * RAD_TO_BIN));
		if (b[31:30] == 2'b01 || b[31:30] == 2'b10)
			b[31] = ~b[31];
		z = longint'($signed(b));
		x = ONE_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		m = root64(abs64(x) * abs64(x) + abs64(y) * abs64(y));
		if (m == 0) begin
			c = ONE_Q30; s = 0;
		end else begin
			c = scale_q30(x, m); s = scale_q30(y, m);
		end
		w = c;
		for (int i = 0; i < 3; i++)
			q[i] = round30(u[i] * s);

		// rotation matrix of the unit quaternion
		xx = q[0] * q[0]; yy = q[1] * q[1]; zz = q[2] * q[2];
		xy = q[0] * q[1]; xz = q[0] * q[2]; yz = q[1] * q[2];
		wx = w * q[0];    wy = w * q[1];    wz = w * q[2];
		one = 64'sd1 << 60;
		r[0][0] = round30(one - 2 * (yy + zz));
		r[0][1] = round30(2 * (xy - wz));
		r[0][2] = round30(2 * (xz + wy));
		r[1][0] = round30(2 * (xy + wz));
		r[1][1] = round30(one - 2 * (xx + zz));
		r[1][2] = round30(2 * (yz - wx));
		r[2][0] = round30(2 * (xz - wy));
		r[2][1] = round30(2 * (yz + wx));
		r[2][2] = round30(one - 2 * (xx + yy));
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += r[i][j] * v[j];
			res.rot[i] = clamp32(round30(acc));
		end
		res.degen = 1'b0;
		return res;
	endfunction

	// ---------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		rotation_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rotations.size() == 0) begin
				report_mismatch("unexpected word", {m_axis_tdata[31:0]}, 32'h0);
			end else begin
				exp_r = expected_rotations.pop_front();
				if (m_axis_tdata[31:0] !== exp_r.rot[0])
					report_mismatch("rot_x", m_axis_tdata[31:0], exp_r.rot[0]);
				if (m_axis_tdata[63:32] !== exp_r.rot[1])
					report_mismatch("rot_y", m_axis_tdata[63:32], exp_r.rot[1]);
				if (m_axis_tdata[95:64] !== exp_r.rot[2])
					report_mismatch("rot_z", m_axis_tdata[95:64], exp_r.rot[2]);
				if (m_axis_tuser !== exp_r.degen)
					report_mismatch("axis_degenerate", {31'd0, m_axis_tuser},
						{31'd0, exp_r.degen});
			end
		end
	end

	// receiver stall pattern: free, random, mostly stalled
	always @(negedge clk) begin
		int unsigned phase;
		phase = ($realtime / 10) / 80;
		case (phase % 3)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// ---------------------------------------------------------------
	// send one input word; called and returns at a falling edge
	task automatic send_word(input logic [31:0] vx, vy, vz, ang, ax, ay, az);
		int gap;
		s_axis_tdata  = {az, ay, ax, ang, vz, vy, vx};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_rotations.push_back(rotate_vector(s_axis_tdata, epsilon_shadow));
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// wait until every word is back and the pipeline has settled
	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (expected_rotations.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_epsilon(input logic [15:0] value);
		drain_results();
		cfg_data  = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		epsilon_shadow = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_small(input int unsigned lim);
		return $urandom_range(0, 1) ? $urandom_range(0, lim) : -$urandom_range(0, lim);
	endfunction

	// ---------------------------------------------------------------
	task automatic test_directed();
		logic [31:0] mx, mn, pi_q, one;
		mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
		pi_q = 32'd843314857; one = 32'h0001_0000;
		// zero angle, unit axes, extremes of the vector
		send_word(mx, mn, one, 0, one, 0, 0);
		send_word(mn, mx, 0, 0, 0, 0, one);
		// quarter turns about each axis
		send_word(one, one * 2, one * 3, pi_q / 2, one, 0, 0);
		send_word(one, one * 2, one * 3, pi_q / 2, 0, one, 0);
		send_word(one, one * 2, one * 3, -(pi_q / 2), 0, 0, one);
		// half turn and angles beyond pi, both signs, full range
		send_word(one, -one, one, pi_q, one, one, one);
		send_word(one * 5, 0, -one, mx, one, 0, one);
		send_word(one * 5, 0, -one, mn, 0, one, one);
		send_word(one, one, 0, pi_q + pi_q / 3, 0, 0, one);
		// saturation: a 45 degree turn of a full-scale vector
		send_word(mx, mx, mx, pi_q / 4, 0, 0, one);
		send_word(mn, mn, mn, pi_q / 4, 0, 0, one);
		// short axes: zero, at the threshold and just above it
		send_word(one, 2 * one, 3 * one, pi_q / 3, 0, 0, 0);
		send_word(one, 2 * one, 3 * one, pi_q / 3, 1, 0, 0);
		send_word(one, 2 * one, 3 * one, pi_q / 3, 0, -2, 0);
		// full-scale axis components
		send_word(one, one, one, pi_q / 5, mx, mx, mx);
		send_word(one, one, one, pi_q / 5, mn, mn, mn);
		send_word(mx, mn, mx, pi_q / 7, mn, mx, 0);
	endtask

	task automatic test_random(input int count);
		logic [31:0] f [7];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 7; i++)
				f[i] = $urandom();
			case ($urandom_range(0, 5))
				0: for (int i = 0; i < 3; i++) f[i] = rand_small(32'h0010_0000);
				1: for (int i = 4; i < 7; i++) f[i] = rand_small(32'h0002_0000);
				2: for (int i = 4; i < 7; i++) f[i] = rand_small(64);
				3: begin
					f[4 + $urandom_range(0, 2)] = 0;
					f[4 + $urandom_range(0, 2)] = 0;
				end
				default: ;
			endcase
			send_word(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
		end
	endtask

	task automatic test_epsilon_range();
		write_epsilon(16'd0);
		test_directed();
		test_random(150);
		write_epsilon(16'hFFFF);
		test_directed();
		test_random(150);
		write_epsilon(16'($urandom_range(2, 16'hFFFE)));
		test_random(150);
		write_epsilon(16'd1);
	endtask

	// ---------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(350);
		// hold the sender until the pipeline is empty
		drain_results();
		test_random(100);
		test_epsilon_range();
		test_random(200);
		drain_results();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
